>>> src/wgsm_pkg.sv
`timescale 1ns / 1ps

package wgsm_pkg;

  // reference capacity and derived widths
  localparam int MAX_REF_LEN = 4096;
  localparam int SYM_W       = 8;
  localparam int SYMBOLS     = 1 << SYM_W;
  localparam int ADDR_W      = $clog2(MAX_REF_LEN);
  localparam int LEN_W       = $clog2(MAX_REF_LEN + 1);

  // pass counters
  localparam int IDX_W = 16;
  localparam int CNT_W = 13;
  localparam int WIN_W = 16;
  localparam int CMP_W = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // opcodes
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPARE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WIN_SIZE         = 1'b0;
  localparam logic REG_WINDOW_UNBOUNDED = 1'b1;

endpackage

>>> src/wgsm_in_if.sv
`timescale 1ns / 1ps

interface wgsm_in_if;
  logic                        valid;
  logic                        ready;
  logic [wgsm_pkg::OP_W-1:0]   opcode;
  logic [wgsm_pkg::SYM_W-1:0]  data_byte;
  logic                        last_byte;

  modport source (output valid, output opcode, output data_byte, output last_byte,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input last_byte,
                output ready);
endinterface

>>> src/wgsm_out_if.sv
`timescale 1ns / 1ps

interface wgsm_out_if;
  logic                        valid;
  logic                        ready;
  logic [wgsm_pkg::CNT_W-1:0]  match_count;
  logic                        overflow;

  modport source (output valid, output match_count, output overflow, input ready);
  modport sink (input valid, input match_count, input overflow, output ready);
endinterface

>>> src/wgsm_ram.sv
`timescale 1ns / 1ps

module wgsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/windowed_greedy_subsequence_match.sv
`timescale 1ns / 1ps
// load, clear and unused opcodes leave the control idle, so they accept back to back
// a compare byte goes through accept, pointer read, then a scan at one position a cycle,
//   stepping from max(pointer, bound) up to the hit or the reference end
// a pass count is on the output register the cycle after its last compare ends, or
//   once an earlier count leaves it; input waits until then
// sync active-low rst_n clears length, bound, counters and flags; reference store undefined

module windowed_greedy_subsequence_match (
  input  logic                                clk,
  input  logic                                rst_n,
  wgsm_in_if.sink                             in_if,
  wgsm_out_if.source                          out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wgsm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wgsm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wgsm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PTR,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t                         state_r;
  logic [wgsm_pkg::SYM_W-1:0]     sym_r;
  logic                           last_r;
  logic [wgsm_pkg::LEN_W-1:0]     pos_r;
  logic [wgsm_pkg::LEN_W-1:0]     ref_len_r;
  logic [wgsm_pkg::LEN_W-1:0]     nap_r;
  logic [wgsm_pkg::IDX_W-1:0]     cidx_r;
  logic [wgsm_pkg::CNT_W-1:0]     matches_r;
  logic                           pass_r;
  logic                           ovf_r;
  logic [wgsm_pkg::SYMBOLS-1:0]   ptr_valid_r;
  logic [wgsm_pkg::WIN_W-1:0]     win_size_r;
  logic                           win_unb_r;
  logic                           out_valid_r;
  logic [wgsm_pkg::CNT_W-1:0]     out_count_r;
  logic                           out_ovf_r;

  logic                           in_fire;
  logic                           cfg_wr;
  logic                           out_free;
  logic                           out_load;
  logic                           store_we;
  logic [wgsm_pkg::ADDR_W-1:0]    store_raddr;
  logic [wgsm_pkg::SYM_W-1:0]     store_q;
  logic [wgsm_pkg::LEN_W-1:0]     ptr_q;
  logic [wgsm_pkg::LEN_W-1:0]     ptr_eff;
  logic [wgsm_pkg::LEN_W-1:0]     pos_start;
  logic [wgsm_pkg::LEN_W-1:0]     pos_inc;
  logic                           in_range;
  logic                           hit;
  logic                           scan_end;
  logic [wgsm_pkg::CMP_W-1:0]     pos_x;
  logic [wgsm_pkg::CMP_W-1:0]     cidx_x;
  logic [wgsm_pkg::CMP_W-1:0]     fwd_dist;
  logic                           win_ok;
  logic                           take;
  logic [wgsm_pkg::CNT_W-1:0]     matches_nxt;

  // handshakes
  assign in_fire      = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_if.ready;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign pready       = 1'b1;

  assign out_if.valid       = out_valid_r;
  assign out_if.match_count = out_count_r;
  assign out_if.overflow    = out_ovf_r;

  // register read back
  always_comb begin
    unique case (paddr[2])
      wgsm_pkg::REG_WIN_SIZE:
        prdata = {{(wgsm_pkg::APB_DATA_W - wgsm_pkg::WIN_W){1'b0}}, win_size_r};
      wgsm_pkg::REG_WINDOW_UNBOUNDED:
        prdata = {{(wgsm_pkg::APB_DATA_W - 1){1'b0}}, win_unb_r};
      default:
        prdata = '0;
    endcase
  end

  // reference store: appended by loads, scanned by compares
  assign store_we = in_fire && (in_if.opcode == wgsm_pkg::OP_LOAD) &&
                    (ref_len_r < wgsm_pkg::LEN_W'(wgsm_pkg::MAX_REF_LEN));
  assign pos_inc  = pos_r + 1'b1;

  always_comb begin
    if (state_r == ST_PTR) begin
      store_raddr = pos_start[wgsm_pkg::ADDR_W-1:0];
    end else begin
      store_raddr = pos_inc[wgsm_pkg::ADDR_W-1:0];
    end
  end

  wgsm_ram #(
    .WIDTH (wgsm_pkg::SYM_W),
    .DEPTH (wgsm_pkg::MAX_REF_LEN)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (ref_len_r[wgsm_pkg::ADDR_W-1:0]),
    .wdata (in_if.data_byte),
    .raddr (store_raddr),
    .rdata (store_q)
  );

  // per-symbol search pointers, written back when a scan ends
  wgsm_ram #(
    .WIDTH (wgsm_pkg::LEN_W),
    .DEPTH (wgsm_pkg::SYMBOLS)
  ) u_ptr (
    .clk   (clk),
    .we    (scan_end),
    .waddr (sym_r),
    .wdata (pos_r),
    .raddr (in_if.data_byte),
    .rdata (ptr_q)
  );

  // scan start: pointer, or the bound if the pointer lags behind it
  assign ptr_eff   = ptr_valid_r[sym_r] ? ptr_q : '0;
  assign pos_start = (ptr_eff < nap_r) ? nap_r : ptr_eff;

  // scan step and window test
  assign in_range = (pos_r < ref_len_r);
  assign hit      = in_range && (store_q == sym_r);
  assign scan_end = (state_r == ST_SCAN) && (!in_range || hit);

  assign pos_x    = wgsm_pkg::CMP_W'(pos_r);
  assign cidx_x   = wgsm_pkg::CMP_W'(cidx_r);
  assign fwd_dist = pos_x - cidx_x;
  assign win_ok   = win_unb_r ||
                    ((pos_x >= cidx_x) && (fwd_dist < wgsm_pkg::CMP_W'(win_size_r)));
  assign take     = hit && win_ok;

  assign matches_nxt = (take && (matches_r < wgsm_pkg::CNT_MAX)) ?
                       matches_r + 1'b1 : matches_r;

  // output register loads when a pass ends or a held count can move
  assign out_load = (scan_end && last_r && out_free) ||
                    ((state_r == ST_HOLD) && out_free);

  // control state machine and pass state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_len_r   <= '0;
      nap_r       <= '0;
      cidx_r      <= '0;
      matches_r   <= '0;
      pass_r      <= 1'b0;
      ovf_r       <= 1'b0;
      ptr_valid_r <= '0;
      win_size_r  <= {wgsm_pkg::WIN_W{1'b1}};
      win_unb_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          wgsm_pkg::REG_WIN_SIZE:         win_size_r <= pwdata[wgsm_pkg::WIN_W-1:0];
          wgsm_pkg::REG_WINDOW_UNBOUNDED: win_unb_r  <= pwdata[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sym_r  <= in_if.data_byte;
            last_r <= in_if.last_byte;
            case (in_if.opcode)
              wgsm_pkg::OP_LOAD: begin
                if (store_we) begin
                  ref_len_r <= ref_len_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              wgsm_pkg::OP_CLEAR: begin
                ref_len_r <= '0;
                ovf_r     <= 1'b0;
                pass_r    <= 1'b0;
              end
              wgsm_pkg::OP_COMPARE: begin
                if (!pass_r) begin
                  ptr_valid_r <= '0;
                  nap_r       <= '0;
                  cidx_r      <= '0;
                  matches_r   <= '0;
                  pass_r      <= 1'b1;
                end
                state_r <= ST_PTR;
              end
              default: ;
            endcase
          end
        end
        ST_PTR: begin
          pos_r   <= pos_start;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_end) begin
            ptr_valid_r[sym_r] <= 1'b1;
            matches_r          <= matches_nxt;
            if (take) begin
              nap_r <= pos_inc;
            end
            if (cidx_r < wgsm_pkg::IDX_MAX) begin
              cidx_r <= cidx_r + 1'b1;
            end
            if (last_r) begin
              pass_r <= 1'b0;
              if (out_free) begin
                out_count_r <= matches_nxt;
                out_ovf_r   <= ovf_r;
                state_r     <= ST_IDLE;
              end else begin
                state_r <= ST_HOLD;
              end
            end else begin
              state_r <= ST_IDLE;
            end
          end else begin
            pos_r <= pos_inc;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_count_r <= matches_r;
            out_ovf_r   <= ovf_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // matches never outrun compare bytes in a pass
  a_count_le_index: assert property (@(posedge clk) disable iff (!rst_n)
    wgsm_pkg::IDX_W'(matches_r) <= cidx_r)
    else $error("match count exceeds compare index");

  // clear empties the reference and ends the pass
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_if.opcode == wgsm_pkg::OP_CLEAR) |=>
      (ref_len_r == '0) && !ovf_r && !pass_r)
    else $error("clear did not reset reference state");

  // scan position never passes the loaded reference length
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (pos_r <= ref_len_r))
    else $error("scan position beyond reference length");

  // a final compare with a free output register delivers its count next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    scan_end && last_r && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("pass result not presented");

endmodule

>>> bench/windowed_greedy_subsequence_match_tb.sv
`timescale 1ns / 1ps

module windowed_greedy_subsequence_match_tb;

  localparam logic [wgsm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 140;

  typedef struct packed {
    logic [wgsm_pkg::CNT_W-1:0] count;
    logic                       overflow;
  } pass_result_t;

  // tracks reference contents and pass state, holds the counts still owed
  class match_count_tracker;
    logic [wgsm_pkg::SYM_W-1:0] ref_bytes [wgsm_pkg::MAX_REF_LEN];
    logic [wgsm_pkg::LEN_W-1:0] ref_len;
    logic [wgsm_pkg::LEN_W-1:0] sym_ptr [wgsm_pkg::SYMBOLS];
    logic [wgsm_pkg::LEN_W-1:0] bound;
    logic [wgsm_pkg::IDX_W-1:0] cmp_idx;
    logic [wgsm_pkg::CNT_W-1:0] match_tally;
    logic                       pass_on;
    logic                       dropped;
    logic [wgsm_pkg::WIN_W-1:0] win_size;
    logic                       win_unbounded;
    pass_result_t               expected_counts [$];
    int                         errors;

    function new();
      ref_len       = '0;
      bound         = '0;
      cmp_idx       = '0;
      match_tally   = '0;
      pass_on       = 1'b0;
      dropped       = 1'b0;
      win_size      = '1;
      win_unbounded = 1'b1;
      errors        = 0;
      foreach (sym_ptr[s]) sym_ptr[s] = '0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return expected_counts.size();
    endfunction

    // greedy forward search for one compare byte
    function void scan_for_symbol(logic [wgsm_pkg::SYM_W-1:0] sym);
      logic [wgsm_pkg::LEN_W-1:0] pos;
      pos = sym_ptr[sym];
      if (pos < bound) pos = bound;
      while (pos < ref_len && ref_bytes[pos] != sym) pos++;
      sym_ptr[sym] = pos;
      if (pos < ref_len && (win_unbounded ||
          (pos >= cmp_idx && int'(pos) - int'(cmp_idx) < int'(win_size)))) begin
        bound = pos + 1'b1;
        if (match_tally != wgsm_pkg::CNT_MAX) match_tally++;
      end
      if (cmp_idx != wgsm_pkg::IDX_MAX) cmp_idx++;
    endfunction

    function void take_item(logic [wgsm_pkg::OP_W-1:0] op,
                            logic [wgsm_pkg::SYM_W-1:0] sym, logic lst);
      pass_result_t res;
      case (op)
        wgsm_pkg::OP_LOAD: begin
          if (int'(ref_len) < wgsm_pkg::MAX_REF_LEN) begin
            ref_bytes[ref_len] = sym;
            ref_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        wgsm_pkg::OP_CLEAR: begin
          ref_len = '0;
          dropped = 1'b0;
          pass_on = 1'b0;
        end
        wgsm_pkg::OP_COMPARE: begin
          // first compare byte of a pass resets the search state
          if (!pass_on) begin
            foreach (sym_ptr[s]) sym_ptr[s] = '0;
            bound       = '0;
            cmp_idx     = '0;
            match_tally = '0;
            pass_on     = 1'b1;
          end
          scan_for_symbol(sym);
          if (lst) begin
            res.count       = match_tally;
            res.overflow    = dropped;
            expected_counts = {expected_counts, res};
            pass_on         = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    task check_count(logic [wgsm_pkg::CNT_W-1:0] count, logic ovf);
      pass_result_t want;
      if (expected_counts.size() == 0) begin
        report($sformatf("unexpected result count=%0d overflow=%0b", count, ovf));
      end else begin
        want = expected_counts.pop_front();
        if (count !== want.count)
          report($sformatf("match_count %0d, expected %0d", count, want.count));
        if (ovf !== want.overflow)
          report($sformatf("overflow %0b, expected %0b", ovf, want.overflow));
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [wgsm_pkg::APB_ADDR_W-1:0] paddr;
  logic [wgsm_pkg::APB_DATA_W-1:0] pwdata;
  logic [wgsm_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  wgsm_in_if  in_ch ();
  wgsm_out_if out_ch ();

  match_count_tracker         tracker;
  int                         items_sent;
  int                         stall_left;
  int                         idle_cycles;
  bit                         quiet;
  bit                         calm;
  logic [wgsm_pkg::SYM_W-1:0] alphabet [4];

  windowed_greedy_subsequence_match uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (quiet || calm) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      tracker.check_count(out_ch.match_count, out_ch.overflow);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [wgsm_pkg::SYM_W-1:0] pick_sym();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 3)];
  endfunction

  task automatic push_item(input logic [wgsm_pkg::OP_W-1:0] op,
                           input logic [wgsm_pkg::SYM_W-1:0] sym,
                           input logic lst);
    int gap;
    gap = (quiet || calm || $urandom_range(0, 5) != 0) ? 0 : $urandom_range(1, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.opcode    = op;
    in_ch.data_byte = sym;
    in_ch.last_byte = lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_item(op, sym, lst);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // let owed counts arrive and any trailing scan finish
  task automatic wait_idle();
    int settle;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    settle = int'(tracker.ref_len) + 8;
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_xfer(input logic wr, input logic reg_idx,
                          input logic [wgsm_pkg::APB_DATA_W-1:0] wdata,
                          output logic [wgsm_pkg::APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {reg_idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_window_regs();
    logic [wgsm_pkg::APB_DATA_W-1:0] rd;
    cfg_xfer(1'b0, wgsm_pkg::REG_WIN_SIZE, '0, rd);
    if (rd[wgsm_pkg::WIN_W-1:0] !== tracker.win_size)
      tracker.report($sformatf("window size read %0d, expected %0d",
                               rd[wgsm_pkg::WIN_W-1:0], tracker.win_size));
    cfg_xfer(1'b0, wgsm_pkg::REG_WINDOW_UNBOUNDED, '0, rd);
    if (rd[0] !== tracker.win_unbounded)
      tracker.report($sformatf("window unbounded read %0b, expected %0b",
                               rd[0], tracker.win_unbounded));
  endtask

  task automatic set_window(input logic [wgsm_pkg::WIN_W-1:0] size, input logic unb);
    logic [wgsm_pkg::APB_DATA_W-1:0] rd;
    cfg_xfer(1'b1, wgsm_pkg::REG_WIN_SIZE, {16'($urandom), size}, rd);
    tracker.win_size = size;
    cfg_xfer(1'b1, wgsm_pkg::REG_WINDOW_UNBOUNDED, {31'($urandom), unb}, rd);
    tracker.win_unbounded = unb;
    check_window_regs();
  endtask

  // one pass: optional clear, loads, then compares with some noise mixed in
  task automatic random_pass();
    int n_load;
    int n_cmp;
    calm = ($urandom_range(0, 3) == 0);
    foreach (alphabet[k]) alphabet[k] = 8'($urandom);
    if (int'(tracker.ref_len) > 150 || $urandom_range(0, 2) == 0)
      push_item(wgsm_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
    n_load = $urandom_range(0, 20);
    repeat (n_load) push_item(wgsm_pkg::OP_LOAD, pick_sym(), $urandom_range(0, 7) == 0);
    n_cmp = $urandom_range(1, 20);
    for (int i = 0; i < n_cmp; i++) begin
      case ($urandom_range(0, 24))
        0: push_item(wgsm_pkg::OP_LOAD, pick_sym(), 1'b0);
        1: push_item(OP_UNUSED, 8'($urandom), 1'($urandom));
        2: push_item(wgsm_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
        default: ;
      endcase
      push_item(wgsm_pkg::OP_COMPARE, pick_sym(), i == n_cmp - 1);
    end
  endtask

  initial begin
    int mark;
    tracker         = new();
    items_sent      = 0;
    stall_left      = 0;
    idle_cycles     = 0;
    quiet           = 1'b0;
    calm            = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = wgsm_pkg::OP_LOAD;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    foreach (alphabet[k]) alphabet[k] = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // registers come out of reset at their defaults
    check_window_regs();

    // compare on an empty reference
    push_item(wgsm_pkg::OP_COMPARE, 8'h00, 1'b1);
    // loads, one with a stray last mark, then an unused opcode
    push_item(wgsm_pkg::OP_LOAD, 8'h00, 1'b0);
    push_item(wgsm_pkg::OP_LOAD, 8'hFF, 1'b0);
    push_item(wgsm_pkg::OP_LOAD, 8'hA5, 1'b0);
    push_item(wgsm_pkg::OP_LOAD, 8'h5A, 1'b0);
    push_item(wgsm_pkg::OP_LOAD, 8'h00, 1'b1);
    push_item(wgsm_pkg::OP_LOAD, 8'hFF, 1'b0);
    push_item(OP_UNUSED, 8'hFF, 1'b1);
    // pass with a load appended mid-pass
    push_item(wgsm_pkg::OP_COMPARE, 8'hFF, 1'b0);
    push_item(wgsm_pkg::OP_COMPARE, 8'h00, 1'b0);
    push_item(wgsm_pkg::OP_LOAD, 8'h77, 1'b0);
    push_item(wgsm_pkg::OP_COMPARE, 8'h77, 1'b0);
    push_item(wgsm_pkg::OP_COMPARE, 8'hA5, 1'b1);
    // clear aborts an open pass
    push_item(wgsm_pkg::OP_COMPARE, 8'h5A, 1'b0);
    push_item(wgsm_pkg::OP_CLEAR, 8'hFF, 1'b1);
    push_item(wgsm_pkg::OP_LOAD, 8'h3C, 1'b0);
    push_item(wgsm_pkg::OP_LOAD, 8'hC3, 1'b0);
    push_item(wgsm_pkg::OP_COMPARE, 8'hC3, 1'b0);
    push_item(wgsm_pkg::OP_COMPARE, 8'h3C, 1'b1);
    wait_idle();

    // random passes under a spread of window settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_window(16'd0, 1'b0);
        1: set_window(16'd1, 1'b0);
        2: set_window(16'hFFFF, 1'b0);
        3: set_window(16'($urandom_range(2, 16)), 1'b0);
        4: set_window(16'($urandom_range(1, 65535)), 1'b1);
        default: set_window(16'($urandom_range(1, 40)), 1'b0);
      endcase
      mark = items_sent;
      while (items_sent - mark < PHASE_ITEMS) random_pass();
      wait_idle();
    end

    // closing stretch with no idling, defaults restored
    quiet = 1'b1;
    set_window(16'hFFFF, 1'b1);
    mark = items_sent;
    while (items_sent - mark < PHASE_ITEMS) random_pass();
    wait_idle();

    if (tracker.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
